### rtl/lis_pkg.sv
// Shared constants and types for the longest-increasing-subsequence length block.
// No dependencies; imported by every module under rtl/.
package lis_pkg;

  // Tail table depth and element width.
  localparam int MAX_LEN    = 1024;
  localparam int DATA_WIDTH = 32;

  // Address of one tail, and a length that can also hold MAX_LEN itself.
  localparam int ADDR_W = $clog2(MAX_LEN);
  localparam int LEN_W  = $clog2(MAX_LEN + 1);

  // Width of the reported length field and of the padded output tdata.
  localparam int LIS_LEN_W  = 11;
  localparam int OUT_DATA_W = ((LIS_LEN_W + 7) / 8) * 8;

  // Access request from the search controller to the tail memory.
  typedef struct packed {
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
  } lis_mem_req_t;

  // One finished result handed from the controller to the output stage.
  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic             is_final;
    logic             ovf;
  } lis_res_t;

endpackage

### rtl/lis_length_stream_top.sv
// Top level of the streaming longest-increasing-subsequence length block.
// Depends on lis_pkg, lis_tail_ram and lis_search_ctrl.
//
// Each input transfer carries one signed value; the block returns one result
// per value with the length of the longest strictly increasing subsequence of
// the sequence so far, a copy of tlast, and an overflow flag that is set once
// an append was dropped because all MAX_LEN tails were in use. The transfer
// with tlast high ends the sequence; the next value starts a new one. The
// smallest tail for each length lives in a one-port-read, one-port-write
// memory, and a binary search over it takes one memory probe per cycle. An
// item occupies the block for the search, a tail update and the hand-off to
// the output register; with an empty table the search is skipped. The number
// of probes grows with the current length, and the hand-off stretches while
// the output register still holds an unread result. The memory needs no
// clearing after reset. A finished result waits in an output register, so the
// next item is taken while the previous result is still unread.
module lis_length_stream_top
  import lis_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_WIDTH-1:0] in_tdata,   // [31:0] value
  input  logic                  in_tlast,
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [10:0] lis_length, rest zero
  output logic                  out_tlast,  // is_final
  output logic                  out_tuser   // [0] overflow
);

  lis_mem_req_t          mem_req;
  logic [DATA_WIDTH-1:0] mem_rd_data;
  logic                  res_valid;
  logic                  res_ready;
  lis_res_t              res;

  logic                  out_valid_r;
  lis_res_t              out_res_r;

  lis_tail_ram u_ram (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  lis_search_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_value    (in_tdata),
    .in_last     (in_tlast),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // Output register takes a new result whenever it is empty or being drained.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_res_r.length[LIS_LEN_W-1:0]);
  assign out_tlast  = out_res_r.is_final;
  assign out_tuser  = out_res_r.ovf;

endmodule

### rtl/lis_tail_ram.sv
// Tail table: single write port, single read port, registered read.
// Depends on lis_pkg for depth and width.
module lis_tail_ram
  import lis_pkg::*;
(
  input  logic                  clk,
  input  lis_mem_req_t          req,
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] mem [MAX_LEN];
  logic [DATA_WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/lis_search_ctrl.sv
// Binary-search sequencer: walks the tail memory one probe per cycle, then
// replaces or appends a tail or flags a full table, and builds the result. Depends on lis_pkg.
module lis_search_ctrl
  import lis_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Item side
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_WIDTH-1:0] in_value,
  input  logic                  in_last,
  // Tail memory
  output lis_mem_req_t          mem_req,
  input  logic [DATA_WIDTH-1:0] mem_rd_data,
  // Result side
  output logic                  res_valid,
  input  logic                  res_ready,
  output lis_res_t              res
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPDATE,
    ST_OUT
  } state_t;

  state_t                state_r, state_nxt;
  logic [LEN_W-1:0]      lo_r, lo_nxt;
  logic [LEN_W-1:0]      hi_r, hi_nxt;
  logic [LEN_W-1:0]      mid_r, mid_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [DATA_WIDTH-1:0] value_r, value_nxt;
  logic                  last_r, last_nxt;
  lis_res_t              res_r, res_nxt;

  logic                  tail_less;
  logic [LEN_W-1:0]      lo_new, hi_new, mid_new, len_new;
  logic                  ovf_new;

  // Probe outcome and the next probe position for either direction.
  always_comb begin
    tail_less = $signed(mem_rd_data) < $signed(value_r);
    lo_new    = tail_less ? (mid_r + LEN_W'(1)) : lo_r;
    hi_new    = tail_less ? hi_r : mid_r;
    mid_new   = lo_new + ((hi_new - lo_new) >> 1);
  end

  // Next-state and datapath logic.
  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    value_nxt = value_r;
    last_nxt  = last_r;
    res_nxt   = res_r;
    len_new   = len_r;
    ovf_new   = ovf_r;
    mem_req   = '0;
    in_ready  = 1'b0;
    res_valid = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          value_nxt = in_value;
          last_nxt  = in_last;
          lo_nxt    = '0;
          hi_nxt    = len_r;
          // The first probe goes out in the same cycle as the transfer.
          if (len_r != '0) begin
            mid_nxt         = len_r >> 1;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = mid_nxt[ADDR_W-1:0];
            state_nxt       = ST_CMP;
          end else begin
            state_nxt = ST_UPDATE;
          end
        end
      end

      ST_CMP: begin
        lo_nxt  = lo_new;
        hi_nxt  = hi_new;
        mid_nxt = mid_new;
        if (lo_new < hi_new) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = mid_new[ADDR_W-1:0];
        end else begin
          state_nxt = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        // Replace the found tail, append a new one, or flag a full table.
        mem_req.wr_data = value_r;
        if (lo_r < len_r) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = lo_r[ADDR_W-1:0];
        end else if (len_r < LEN_W'(MAX_LEN)) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = len_r[ADDR_W-1:0];
          len_new         = len_r + LEN_W'(1);
        end else begin
          ovf_new = 1'b1;
        end
        res_nxt.length   = len_new;
        res_nxt.is_final = last_r;
        res_nxt.ovf      = ovf_new;
        // The last item of a sequence starts the next one from empty.
        if (last_r) begin
          len_nxt = '0;
          ovf_nxt = 1'b0;
        end else begin
          len_nxt = len_new;
          ovf_nxt = ovf_new;
        end
        state_nxt = ST_OUT;
      end

      ST_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      ovf_r   <= ovf_nxt;
    end
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    value_r <= value_nxt;
    last_r  <= last_nxt;
    res_r   <= res_nxt;
  end

  assign res = res_r;

endmodule

### test/tb_lis_length_stream_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for lis_length_stream_top: directed table, overflow run, random
// sequences; results match a patience-search predictor or typed rows. Depends on lis_pkg.
module tb_lis_length_stream_top;
  import lis_pkg::*;

  // Run control.
  localparam int DIR_ROWS    = 24;
  localparam int RANDOM_END  = 1150;     // total items, long overflow sequence included
  localparam int HOLD_CYCLES = 300;
  // Watchdog limit for the whole run of about 1150 items, sender gaps, receiver stalls
  // and the long hold-off included, with a wide margin.
  localparam int CYCLE_LIMIT = 600000;

  // One expected result.
  typedef struct packed {
    logic [LIS_LEN_W-1:0] len;
    logic                 fin;
    logic                 ovf;
  } lis_result_t;

  // One directed row; the expectation is used only when typed is set.
  typedef struct {
    logic [DATA_WIDTH-1:0] value;
    logic                  last;
    bit                    typed;
    lis_result_t           want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [DATA_WIDTH-1:0] in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;

  // Predictor state: smallest tail per length, running length and overflow flag.
  logic signed [DATA_WIDTH-1:0] lis_tails [MAX_LEN];
  int                           lis_run_len = 0;
  bit                           lis_run_ovf = 1'b0;

  lis_result_t lis_expected [$];
  lis_result_t got_want;
  int          errors = 0;
  int          cycle_count = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  bit          hold_req = 1'b0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // First value after reset is the negative extreme, then the positive one.
    '{32'h8000_0000, 1'b0, 1'b1, '{11'd1, 1'b0, 1'b0}},
    '{32'h7FFF_FFFF, 1'b0, 1'b1, '{11'd2, 1'b0, 1'b0}},
    // Equal value changes nothing.
    '{32'h7FFF_FFFF, 1'b0, 1'b1, '{11'd2, 1'b0, 1'b0}},
    '{32'h0000_0000, 1'b0, 1'b1, '{11'd2, 1'b0, 1'b0}},
    // Last marker reports the length, then the next sequence starts empty.
    '{32'h8000_0000, 1'b1, 1'b1, '{11'd2, 1'b1, 1'b0}},
    '{32'h0000_0005, 1'b1, 1'b1, '{11'd1, 1'b1, 1'b0}},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, '{11'd1, 1'b0, 1'b0}},
    '{32'h0000_0000, 1'b0, 1'b1, '{11'd2, 1'b0, 1'b0}},
    '{32'h0000_0001, 1'b0, 1'b1, '{11'd3, 1'b0, 1'b0}},
    '{32'hFFFF_FFFE, 1'b0, 1'b1, '{11'd3, 1'b0, 1'b0}},
    '{32'h8000_0000, 1'b0, 1'b1, '{11'd3, 1'b0, 1'b0}},
    '{32'h7FFF_FFFF, 1'b1, 1'b1, '{11'd4, 1'b1, 1'b0}},
    // Strictly decreasing sequence stays at one.
    '{32'h0000_0064, 1'b0, 1'b1, '{11'd1, 1'b0, 1'b0}},
    '{32'h0000_0032, 1'b0, 1'b1, '{11'd1, 1'b0, 1'b0}},
    '{32'hFFFF_FFCE, 1'b0, 1'b1, '{11'd1, 1'b0, 1'b0}},
    '{32'h8000_0000, 1'b1, 1'b1, '{11'd1, 1'b1, 1'b0}},
    // Mixed values, checked against the predictor.
    '{32'h1234_5678, 1'b0, 1'b0, '0},
    '{32'h0F0F_0F0F, 1'b0, 1'b0, '0},
    '{32'hDEAD_BEEF, 1'b0, 1'b0, '0},
    '{32'h2000_0000, 1'b0, 1'b0, '0},
    '{32'h2000_0001, 1'b0, 1'b0, '0},
    '{32'hA5A5_A5A5, 1'b1, 1'b0, '0},
    '{32'h5555_5555, 1'b1, 1'b0, '0},
    '{32'hAAAA_AAAA, 1'b1, 1'b0, '0}
  };

  lis_length_stream_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [31:0] value
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [10:0] lis_length, rest zero
    .out_tlast (out_tlast),  // is_final
    .out_tuser (out_tuser)   // [0] overflow
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_lis_length_stream_top failed");
      $finish;
    end
  end

  // Patience step: binary search for the first tail not less than the value, then
  // replace it or append. A full table drops the append and flags overflow.
  function automatic lis_result_t lis_predict(input logic signed [DATA_WIDTH-1:0] v,
                                              input logic l);
    int          lo;
    int          hi;
    int          mid;
    lis_result_t r;
    lo = 0;
    hi = lis_run_len;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (lis_tails[mid] < v) lo = mid + 1;
      else hi = mid;
    end
    if (lo < lis_run_len) begin
      lis_tails[lo] = v;
    end else if (lis_run_len < MAX_LEN) begin
      lis_tails[lis_run_len] = v;
      lis_run_len++;
    end else begin
      lis_run_ovf = 1'b1;
    end
    r.len = LIS_LEN_W'(lis_run_len);
    r.fin = l;
    r.ovf = lis_run_ovf;
    if (l) begin
      lis_run_len = 0;
      lis_run_ovf = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < 100)
      $display("ERROR cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    errors++;
  endtask

  // Result checker: each result transfer is compared with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (lis_expected.size() == 0) begin
        report_mismatch("result with no expectation, tdata", 32'(out_tdata), 32'h0);
      end else begin
        got_want = lis_expected.pop_front();
        if (out_tdata !== {{(OUT_DATA_W - LIS_LEN_W){1'b0}}, got_want.len})
          report_mismatch("lis_length", 32'(out_tdata), 32'(got_want.len));
        if (out_tlast !== got_want.fin)
          report_mismatch("is_final", 32'(out_tlast), 32'(got_want.fin));
        if (out_tuser !== got_want.ovf)
          report_mismatch("overflow", 32'(out_tuser), 32'(got_want.ovf));
      end
    end
  end

  // Receiver: stalls on a random pattern that is redrawn after a random stretch, and holds
  // off completely for a long stretch when asked.
  initial begin : receiver
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(5, 80);
        end
        mode_left--;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Offers one item from a negedge, in bursts with random gaps, and records the
  // expectation when the transfer happens. Returns at a negedge.
  task automatic send_item(input logic [DATA_WIDTH-1:0] v, input logic l, input bit typed,
                           input lis_result_t want);
    int          gap;
    lis_result_t pred;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    pred = lis_predict(v, l);
    lis_expected = {lis_expected, (typed ? want : pred)};
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // Stops offering and waits until every expected result has come.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (lis_expected.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // One sequence of random content; the shape depends on the kind.
  task automatic random_sequence(input int kind, input int len);
    logic [DATA_WIDTH-1:0]        v;
    logic signed [DATA_WIDTH-1:0] acc;
    int                           i;
    if (kind >= 5) kind = 1;
    acc = 32'(int'($urandom_range(0, 2000000)) - 1000000);
    for (i = 0; i < len; i++) begin
      case (kind)
        0: v = $urandom;
        1: begin
          // Mostly increasing, with an occasional value that replaces a tail.
          if ($urandom_range(0, 5) == 0) begin
            v = acc - $urandom_range(0, 5000);
          end else begin
            acc = acc + $urandom_range(1, 1000);
            v = acc;
          end
        end
        2: v = 32'(int'($urandom_range(0, 8)) - 4);
        3: begin
          acc = acc - $urandom_range(0, 1000);
          v = acc;
        end
        default: begin
          case ($urandom_range(0, 5))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = '1;
            3: v = '0;
            4: v = 32'd1;
            default: v = $urandom;
          endcase
        end
      endcase
      send_item(v, i == len - 1, 1'b0, '0);
    end
  endtask

  // Fills the whole tail table, then drives past it so appends are dropped.
  task automatic overflow_run();
    logic [DATA_WIDTH-1:0] base;
    int                    i;
    lis_result_t           want;
    base = 32'h9000_0000;
    for (i = 0; i < MAX_LEN; i++)
      send_item(base + 32'(i * 4) + $urandom_range(0, 3), 1'b0, 1'b0, '0);
    // Table full: the append is dropped and overflow is set.
    send_item(32'h7FFF_FFFE, 1'b0, 1'b0, '0);
    // A replacement still happens while the table is full.
    send_item(base + 32'd2048, 1'b0, 1'b0, '0);
    send_item(32'h7FFF_FFFF, 1'b0, 1'b0, '0);
    want = '{len: LIS_LEN_W'(MAX_LEN), fin: 1'b1, ovf: 1'b1};
    send_item(32'h7FFF_FFFF, 1'b1, 1'b1, want);
  endtask

  // Main stimulus: reset, directed table, overflow sequence, random sequences, final drain.
  initial begin : stimulus
    int  r;
    int  kind;
    int  len;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (r = 0; r < DIR_ROWS; r++)
      send_item(dir_rows[r].value, dir_rows[r].last, dir_rows[r].typed, dir_rows[r].want);
    drain();

    // Fill the table past its end, then wait for every result before going on.
    overflow_run();
    drain();

    // The receiver holds off for a long stretch while random items keep coming.
    hold_req = 1'b1;
    while (items_sent < RANDOM_END) begin
      kind = $urandom_range(0, 6);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 250) : $urandom_range(1, 30);
      if (len > RANDOM_END - items_sent) len = RANDOM_END - items_sent;
      random_sequence(kind, len);
    end

    drain();
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("tb_lis_length_stream_top passed");
    end else begin
      $display("tb_lis_length_stream_top failed");
    end
    $finish;
  end

endmodule

### lis_length_stream_top.f
rtl/lis_pkg.sv
rtl/lis_tail_ram.sv
rtl/lis_search_ctrl.sv
rtl/lis_length_stream_top.sv
test/tb_lis_length_stream_top.sv
